// ===== design/mfep_pkg.sv =====
// Shared types and constants for the MIDI file event parser.
package mfep_pkg;

    // Parser position within the file
    typedef enum logic [3:0] {
        PH_HDR      = 4'd0,
        PH_HDR_SKIP = 4'd1,
        PH_TRK      = 4'd2,
        PH_DELTA    = 4'd3,
        PH_STATUS   = 4'd4,
        PH_DATA1    = 4'd5,
        PH_DATA2    = 4'd6,
        PH_MTYPE    = 4'd7,
        PH_LEN      = 4'd8,
        PH_PAYLOAD  = 4'd9,
        PH_DONE     = 4'd10
    } phase_t;

    typedef enum logic [2:0] {
        EV_HEADER     = 3'd0,
        EV_NOTE_ON    = 3'd1,
        EV_NOTE_OFF   = 3'd2,
        EV_TEMPO      = 3'd3,
        EV_END_TRACK  = 3'd4,
        EV_END_FILE   = 3'd5,
        EV_STATUS_ERR = 3'd6
    } event_kind_t;

    localparam logic [7:0] STATUS_META     = 8'hFF;
    localparam logic [7:0] STATUS_SYSEX    = 8'hF0;
    localparam logic [7:0] STATUS_ESCAPE   = 8'hF7;
    localparam logic [7:0] META_TEMPO      = 8'h51;
    localparam logic [7:0] META_END_TRACK  = 8'h2F;
    localparam logic [3:0] HI_NOTE_OFF     = 4'h8;
    localparam logic [3:0] HI_NOTE_ON      = 4'h9;
    localparam logic [3:0] HI_PROG_CHANGE  = 4'hC;
    localparam logic [3:0] HI_CHAN_PRESS   = 4'hD;
    localparam logic [3:0] HI_SYSTEM       = 4'hF;

    // Header chunk byte positions
    localparam logic [3:0] HDR_LAST_BYTE   = 4'd13;
    localparam logic [3:0] TRK_LAST_BYTE   = 4'd7;
    localparam logic [31:0] HDR_STD_LEN    = 32'd6;
    localparam logic [3:0] TEMPO_BYTES     = 4'd3;

    // BPM divider: 60e6 / tempo, one quotient bit per cycle
    localparam int DIVIDEND_W = 26;
    localparam logic [DIVIDEND_W-1:0] BPM_DIVIDEND = 26'd60000000;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef struct packed {
        event_kind_t  kind;
        logic [3:0]   channel;
        logic [7:0]   note;
        logic [7:0]   velocity;
        logic [31:0]  wall_time;
        logic [15:0]  divisions;
        logic [15:0]  track_count;
        logic [23:0]  tempo_us;
        logic [15:0]  bpm;
    } result_t;

endpackage

// ===== design/midi_file_event_parser.sv =====
// Top level: byte-serial standard MIDI file parser with event output buffer.
//
//  channel | ports                    | payload
//  --------+--------------------------+-------------------------------------------
//  in      | s_tvalid s_tready s_tdata | one file byte
//  out     | m_tvalid m_tready m_tdata | note / time / header / tempo fields
//          | m_tuser                   | event kind
//
// One file byte per cycle while s_tready is high. The byte that completes a set-tempo event
// stalls the input while the restoring divider produces one BPM quotient bit per cycle.
// aresetn is synchronous, active low, and puts the parser at the file header.
// A two-deep output buffer lets bytes keep flowing while one event waits; s_tready
// drops when both entries are full or while the divider runs.
module midi_file_event_parser import mfep_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // channel, note, velocity, wall_time, divisions,
                                    // track_count, tempo_us, bpm; [127:124] zero
    output logic [2:0]   m_tuser    // [2:0] event_kind
);

    phase_t       phase_reg, phase_next, pd_phase;
    logic [3:0]   byte_cnt_reg, byte_cnt_next;
    logic [31:0]  len_acc_reg, len_acc_next;
    logic [31:0]  skip_reg, skip_next;
    logic [31:0]  track_time_reg, track_time_next;
    logic [7:0]   running_reg, running_next;
    logic [7:0]   cur_status_reg, cur_status_next;
    logic [7:0]   first_data_reg, first_data_next;
    logic [7:0]   meta_type_reg, meta_type_next;
    logic [23:0]  tempo_reg, tempo_next;
    logic         tempo_seen_reg, tempo_seen_next;
    logic [15:0]  tracks_total_reg, tracks_total_next;
    logic [15:0]  tracks_done_reg, tracks_done_next;
    logic [15:0]  tpq_reg, tpq_next;
    logic [15:0]  bpm_reg;

    logic         s_accept, pop, push;
    logic [7:0]   b;
    logic [31:0]  len_shift;
    logic         pd, meta_tempo, meta_eot, last_track, run_cd, cur_cd;
    logic [15:0]  done_inc;
    logic         emit;
    event_kind_t  kind;
    logic [3:0]   ev_channel;
    logic [7:0]   ev_note, ev_velocity;
    logic         tempo_launch;
    result_t      ev_result, push_data;

    result_t      hold_reg;
    logic         pend_reg;
    result_t      out_reg, skid_reg;
    logic         out_v_reg, skid_v_reg;

    div_status_t  div_st;
    logic [15:0]  div_q;

    assign b          = s_tdata;
    assign s_tready   = !pend_reg && !skid_v_reg;
    assign s_accept   = s_tvalid && s_tready;
    assign len_shift  = {len_acc_reg[24:0], b[6:0]};
    assign meta_tempo = (cur_status_reg == STATUS_META) && (meta_type_reg == META_TEMPO);
    assign meta_eot   = (cur_status_reg == STATUS_META) && (meta_type_reg == META_END_TRACK);
    assign done_inc   = tracks_done_reg + 16'd1;
    assign last_track = done_inc >= tracks_total_reg;
    assign run_cd     = (running_reg[7:4] == HI_PROG_CHANGE) ||
                        (running_reg[7:4] == HI_CHAN_PRESS);
    assign cur_cd     = (cur_status_reg[7:4] == HI_PROG_CHANGE) ||
                        (cur_status_reg[7:4] == HI_CHAN_PRESS);
    assign pd = ((phase_reg == PH_LEN) && !b[7] && (len_shift == '0)) ||
                ((phase_reg == PH_PAYLOAD) && (skip_reg == 32'd1));

    // Where the parser goes once a meta or sysex payload is consumed
    always_comb begin
        if (meta_tempo) begin
            pd_phase = PH_DELTA;
        end else if (meta_eot) begin
            pd_phase = last_track ? PH_DONE : PH_TRK;
        end else begin
            pd_phase = PH_DELTA;
        end
    end

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HDR: begin
                if (byte_cnt_reg == HDR_LAST_BYTE) begin
                    if (tracks_total_reg == '0) begin
                        phase_next = PH_DONE;
                    end else if (len_acc_reg > HDR_STD_LEN) begin
                        phase_next = PH_HDR_SKIP;
                    end else begin
                        phase_next = PH_TRK;
                    end
                end
            end
            PH_HDR_SKIP: begin
                if (skip_reg == 32'd1) phase_next = PH_TRK;
            end
            PH_TRK: begin
                if (byte_cnt_reg == TRK_LAST_BYTE) phase_next = PH_DELTA;
            end
            PH_DELTA: begin
                if (!b[7]) phase_next = PH_STATUS;
            end
            PH_STATUS: begin
                if (!b[7]) begin
                    if (running_reg[7]) phase_next = run_cd ? PH_DELTA : PH_DATA2;
                end else if (b[7:4] != HI_SYSTEM) begin
                    phase_next = PH_DATA1;
                end else if (b == STATUS_META) begin
                    phase_next = PH_MTYPE;
                end else if (b == STATUS_SYSEX || b == STATUS_ESCAPE) begin
                    phase_next = PH_LEN;
                end else begin
                    phase_next = PH_DELTA;
                end
            end
            PH_DATA1:   phase_next = cur_cd ? PH_DELTA : PH_DATA2;
            PH_DATA2:   phase_next = PH_DELTA;
            PH_MTYPE:   phase_next = PH_LEN;
            PH_LEN: begin
                if (!b[7]) phase_next = pd ? pd_phase : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                if (pd) phase_next = pd_phase;
            end
            PH_DONE:    phase_next = PH_DONE;
            default:    phase_next = PH_DONE;
        endcase
    end

    // Event decode
    always_comb begin
        emit        = 1'b0;
        kind        = EV_HEADER;
        ev_channel  = '0;
        ev_note     = '0;
        ev_velocity = '0;
        case (phase_reg)
            PH_HDR: begin
                emit = (byte_cnt_reg == HDR_LAST_BYTE);
            end
            PH_STATUS: begin
                kind = EV_STATUS_ERR;
                if (!b[7]) begin
                    emit = !running_reg[7];
                end else begin
                    emit = (b[7:4] == HI_SYSTEM) && (b != STATUS_META) &&
                           (b != STATUS_SYSEX) && (b != STATUS_ESCAPE);
                end
            end
            PH_DATA2: begin
                ev_channel  = cur_status_reg[3:0];
                ev_note     = first_data_reg;
                ev_velocity = b;
                if ((cur_status_reg[7:4] == HI_NOTE_OFF) ||
                    ((cur_status_reg[7:4] == HI_NOTE_ON) && (b == '0))) begin
                    emit = 1'b1;
                    kind = EV_NOTE_OFF;
                end else if (cur_status_reg[7:4] == HI_NOTE_ON) begin
                    emit = 1'b1;
                    kind = EV_NOTE_ON;
                end
            end
            PH_LEN, PH_PAYLOAD: begin
                if (pd && meta_tempo) begin
                    emit = 1'b1;
                    kind = EV_TEMPO;
                end else if (pd && meta_eot) begin
                    emit = 1'b1;
                    kind = last_track ? EV_END_FILE : EV_END_TRACK;
                end
            end
            default: emit = 1'b0;
        endcase
        if (!emit) begin
            ev_channel  = '0;
            ev_note     = '0;
            ev_velocity = '0;
        end
    end

    // Datapath next values
    always_comb begin
        byte_cnt_next     = byte_cnt_reg;
        len_acc_next      = len_acc_reg;
        skip_next         = skip_reg;
        track_time_next   = track_time_reg;
        running_next      = running_reg;
        cur_status_next   = cur_status_reg;
        first_data_next   = first_data_reg;
        meta_type_next    = meta_type_reg;
        tempo_next        = tempo_reg;
        tempo_seen_next   = tempo_seen_reg;
        tracks_total_next = tracks_total_reg;
        tracks_done_next  = tracks_done_reg;
        tpq_next          = tpq_reg;
        case (phase_reg)
            PH_HDR: begin
                case (byte_cnt_reg) inside
                    [4'd4:4'd7]:   len_acc_next = {len_acc_reg[23:0], b};
                    4'd10, 4'd11:  tracks_total_next = {tracks_total_reg[7:0], b};
                    4'd12, 4'd13:  tpq_next = {tpq_reg[7:0], b};
                    default:       len_acc_next = len_acc_reg;
                endcase
                if (byte_cnt_reg == HDR_LAST_BYTE) begin
                    byte_cnt_next = '0;
                    if (tracks_total_reg != '0 && len_acc_reg > HDR_STD_LEN) begin
                        skip_next = len_acc_reg - HDR_STD_LEN;
                    end
                end else begin
                    byte_cnt_next = byte_cnt_reg + 4'd1;
                end
            end
            PH_HDR_SKIP: begin
                skip_next = skip_reg - 32'd1;
                if (skip_reg == 32'd1) byte_cnt_next = '0;
            end
            PH_TRK: begin
                if (byte_cnt_reg == TRK_LAST_BYTE) begin
                    byte_cnt_next   = '0;
                    track_time_next = '0;
                    running_next    = '0;
                    len_acc_next    = '0;
                end else begin
                    byte_cnt_next = byte_cnt_reg + 4'd1;
                end
            end
            PH_DELTA: begin
                if (b[7]) begin
                    len_acc_next = len_shift;
                end else begin
                    track_time_next = track_time_reg + len_shift;
                    len_acc_next    = '0;
                end
            end
            PH_STATUS: begin
                if (!b[7]) begin
                    if (running_reg[7]) begin
                        cur_status_next = running_reg;
                        if (!run_cd) first_data_next = b;
                    end else begin
                        // stray data byte counts as a one-byte delta
                        track_time_next = track_time_reg + {24'd0, b};
                    end
                end else begin
                    cur_status_next = b;
                    running_next    = (b[7:4] != HI_SYSTEM) ? b : 8'd0;
                    len_acc_next    = '0;
                end
            end
            PH_DATA1: begin
                if (!cur_cd) first_data_next = b;
            end
            PH_MTYPE: begin
                meta_type_next = b;
                len_acc_next   = '0;
            end
            PH_LEN: begin
                if (b[7]) begin
                    len_acc_next = len_shift;
                end else begin
                    skip_next     = len_shift;
                    len_acc_next  = '0;
                    byte_cnt_next = '0;
                end
            end
            PH_PAYLOAD: begin
                if (meta_tempo && !tempo_seen_reg && byte_cnt_reg < TEMPO_BYTES) begin
                    tempo_next    = {tempo_reg[15:0], b};
                    byte_cnt_next = byte_cnt_reg + 4'd1;
                end
                skip_next = skip_reg - 32'd1;
            end
            default: byte_cnt_next = byte_cnt_reg;
        endcase
        if (pd && meta_tempo) tempo_seen_next = 1'b1;
        if (pd && meta_eot) begin
            tracks_done_next = done_inc;
            byte_cnt_next    = '0;
        end
    end

    always_comb begin
        ev_result.kind        = kind;
        ev_result.channel     = ev_channel;
        ev_result.note        = ev_note;
        ev_result.velocity    = ev_velocity;
        ev_result.wall_time   = track_time_reg;
        ev_result.divisions   = tpq_next;
        ev_result.track_count = tracks_total_next;
        ev_result.tempo_us    = tempo_next;
        ev_result.bpm         = bpm_reg;
    end

    // A tempo event waits for its BPM before it joins the output buffer
    assign tempo_launch = s_accept && emit && (kind == EV_TEMPO);

    mfep_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (tempo_launch),
        .divisor  (tempo_next),
        .status   (div_st),
        .quotient (div_q)
    );

    always_comb begin
        push_data = ev_result;
        push      = s_accept && emit && (kind != EV_TEMPO);
        if (div_st.done) begin
            push_data     = hold_reg;
            push_data.bpm = div_q;
            push          = 1'b1;
        end
    end

    assign pop = out_v_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HDR;
            byte_cnt_reg     <= '0;
            len_acc_reg      <= '0;
            skip_reg         <= '0;
            track_time_reg   <= '0;
            running_reg      <= '0;
            cur_status_reg   <= '0;
            first_data_reg   <= '0;
            meta_type_reg    <= '0;
            tempo_reg        <= '0;
            tempo_seen_reg   <= 1'b0;
            tracks_total_reg <= '0;
            tracks_done_reg  <= '0;
            tpq_reg          <= '0;
            bpm_reg          <= '0;
            pend_reg         <= 1'b0;
            out_v_reg        <= 1'b0;
            skid_v_reg       <= 1'b0;
        end else begin
            if (s_accept) begin
                phase_reg        <= phase_next;
                byte_cnt_reg     <= byte_cnt_next;
                len_acc_reg      <= len_acc_next;
                skip_reg         <= skip_next;
                track_time_reg   <= track_time_next;
                running_reg      <= running_next;
                cur_status_reg   <= cur_status_next;
                first_data_reg   <= first_data_next;
                meta_type_reg    <= meta_type_next;
                tempo_reg        <= tempo_next;
                tempo_seen_reg   <= tempo_seen_next;
                tracks_total_reg <= tracks_total_next;
                tracks_done_reg  <= tracks_done_next;
                tpq_reg          <= tpq_next;
            end
            if (tempo_launch) begin
                pend_reg <= 1'b1;
            end else if (div_st.done) begin
                pend_reg <= 1'b0;
                bpm_reg  <= div_q;
            end
            if (pop || !out_v_reg) begin
                if (skid_v_reg) begin
                    out_v_reg  <= 1'b1;
                    skid_v_reg <= push;
                end else begin
                    out_v_reg <= push;
                end
            end else if (push) begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tempo_launch) hold_reg <= ev_result;
        if (pop || !out_v_reg) begin
            if (skid_v_reg) begin
                out_reg <= skid_reg;
                if (push) skid_reg <= push_data;
            end else if (push) begin
                out_reg <= push_data;
            end
        end else if (push) begin
            skid_reg <= push_data;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {4'd0, out_reg.bpm, out_reg.tempo_us, out_reg.track_count,
                       out_reg.divisions, out_reg.wall_time, out_reg.velocity,
                       out_reg.note, out_reg.channel};

    a_no_accept_while_dividing: assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.busy |-> !s_tready)
        else $error("byte accepted while the BPM divider is running");

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry held with the output register empty");

    a_done_has_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.done |-> pend_reg)
        else $error("divider finished with no tempo event waiting");

    a_tempo_stalls_input: assert property (@(posedge aclk) disable iff (!aresetn)
        tempo_launch |=> (!s_tready && div_st.busy))
        else $error("input not stalled after a tempo event");

endmodule

// ===== design/mfep_div.sv =====
// Restoring divider giving saturated BPM from a 24-bit tempo, one bit per cycle.
module mfep_div import mfep_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [23:0] divisor,
    output div_status_t status,
    output logic [15:0] quotient
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [23:0]           rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [23:0]           dsr_reg, dsr_next;
    logic                  zero_reg, zero_next;
    logic [24:0]           trial;
    logic [24:0]           diff;
    logic                  fits;

    assign trial = {rem_reg, dvd_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        zero_next = zero_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS - 1);
            rem_next  = '0;
            dvd_next  = BPM_DIVIDEND;
            quo_next  = '0;
            dsr_next  = divisor;
            zero_next = (divisor == '0);
        end else if (busy_reg) begin
            rem_next = fits ? diff[23:0] : trial[23:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            dvd_next = {dvd_reg[DIVIDEND_W-2:0], 1'b0};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        quo_reg  <= quo_next;
        dsr_reg  <= dsr_next;
        zero_reg <= zero_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;

    always_comb begin
        if (zero_reg) begin
            quotient = '0;
        end else if (|quo_reg[DIVIDEND_W-1:16]) begin
            quotient = 16'hFFFF;
        end else begin
            quotient = quo_reg[15:0];
        end
    end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the byte-serial MIDI file event parser.
module tb;
    import mfep_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned USEC_PER_MINUTE = 60_000_000;
    localparam int unsigned BPM_MAX         = 65_535;
    localparam int          WATCHDOG_LIMIT  = 2000;
    localparam int          SETTLE_CYCLES   = 64;
    localparam int          RANDOM_BYTES    = 120;

    localparam logic [3:0] HI_POLY_PRESS   = 4'hA;
    localparam logic [3:0] HI_CONTROL      = 4'hB;
    localparam logic [3:0] HI_PITCH_BEND   = 4'hE;
    localparam logic [7:0] META_TRACK_NAME = 8'h03;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [2:0]   m_tuser;

    always #6 aclk = ~aclk;

    midi_file_event_parser u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Parser state as predicted from the accepted bytes
    phase_t      ph        = PH_HDR;
    logic [3:0]  hdr_cnt   = '0;
    logic [31:0] len_acc   = '0;
    logic [31:0] skip_left = '0;
    logic [31:0] t_time    = '0;
    logic [7:0]  run_stat  = '0;
    logic [7:0]  cur_stat  = '0;
    logic [7:0]  data1     = '0;
    logic [7:0]  mtype     = '0;
    logic [23:0] tempo     = '0;
    logic        tempo_got = 1'b0;
    logic [15:0] n_tracks  = '0;
    logic [15:0] n_done    = '0;
    logic [15:0] tpq       = '0;

    result_t pending_events[$];

    int   n_errors     = 0;
    int   n_bytes      = 0;
    int   n_seen       = 0;
    int   n_kind [8];
    int   quiet_cycles = 0;
    bit   src_idle_on  = 1'b1;
    bit   sink_idle_on = 1'b1;
    int   ready_hold   = 0;

    logic [15:0] file_tracks;
    logic [15:0] file_div;

    function automatic void expect_event(input event_kind_t kind, input logic [3:0] ch,
                                         input logic [7:0] nt, input logic [7:0] vel);
        result_t     e;
        int unsigned q;
        q = 0;
        if (tempo != 0) begin
            q = USEC_PER_MINUTE / 32'(tempo);
            if (q > BPM_MAX)
                q = BPM_MAX;
        end
        e.kind        = kind;
        e.channel     = ch;
        e.note        = nt;
        e.velocity    = vel;
        e.wall_time   = t_time;
        e.divisions   = tpq;
        e.track_count = n_tracks;
        e.tempo_us    = tempo;
        e.bpm         = q[15:0];
        pending_events.push_back(e);
    endfunction

    function automatic void start_delta();
        len_acc = '0;
        ph      = PH_DELTA;
    endfunction

    function automatic void first_data_byte(input logic [7:0] b);
        if (cur_stat[7:4] == HI_PROG_CHANGE || cur_stat[7:4] == HI_CHAN_PRESS) begin
            start_delta();
        end else begin
            data1 = b;
            ph    = PH_DATA2;
        end
    endfunction

    function automatic void payload_consumed();
        if (cur_stat == STATUS_META && mtype == META_TEMPO) begin
            tempo_got = 1'b1;
            start_delta();
            expect_event(EV_TEMPO, '0, '0, '0);
        end else if (cur_stat == STATUS_META && mtype == META_END_TRACK) begin
            n_done = n_done + 16'd1;
            if (n_done >= n_tracks) begin
                ph = PH_DONE;
                expect_event(EV_END_FILE, '0, '0, '0);
            end else begin
                hdr_cnt = '0;
                ph      = PH_TRK;
                expect_event(EV_END_TRACK, '0, '0, '0);
            end
        end else begin
            start_delta();
        end
    endfunction

    // Advance the predicted parser by one accepted file byte
    function automatic void parse_byte(input logic [7:0] b);
        case (ph)
            PH_HDR: begin
                if (hdr_cnt inside {[4'd4:4'd7]})
                    len_acc = {len_acc[23:0], b};
                else if (hdr_cnt inside {[4'd10:4'd11]})
                    n_tracks = {n_tracks[7:0], b};
                else if (hdr_cnt inside {[4'd12:4'd13]})
                    tpq = {tpq[7:0], b};
                if (hdr_cnt < HDR_LAST_BYTE) begin
                    hdr_cnt++;
                end else begin
                    hdr_cnt = '0;
                    if (n_tracks == 0) begin
                        ph = PH_DONE;
                    end else if (len_acc > HDR_STD_LEN) begin
                        skip_left = len_acc - HDR_STD_LEN;
                        ph        = PH_HDR_SKIP;
                    end else begin
                        ph = PH_TRK;
                    end
                    expect_event(EV_HEADER, '0, '0, '0);
                end
            end
            PH_HDR_SKIP: begin
                skip_left--;
                if (skip_left == 0) begin
                    hdr_cnt = '0;
                    ph      = PH_TRK;
                end
            end
            PH_TRK: begin
                if (hdr_cnt < TRK_LAST_BYTE) begin
                    hdr_cnt++;
                end else begin
                    hdr_cnt  = '0;
                    t_time   = '0;
                    run_stat = '0;
                    start_delta();
                end
            end
            PH_DELTA: begin
                len_acc = {len_acc[24:0], b[6:0]};
                if (!b[7]) begin
                    t_time  = t_time + len_acc;
                    len_acc = '0;
                    ph      = PH_STATUS;
                end
            end
            PH_STATUS: begin
                if (!b[7]) begin
                    if (run_stat[7]) begin
                        cur_stat = run_stat;
                        first_data_byte(b);
                    end else begin
                        // reported first, then taken as a one-byte delta
                        expect_event(EV_STATUS_ERR, '0, '0, '0);
                        t_time = t_time + {24'd0, b};
                    end
                end else begin
                    cur_stat = b;
                    if (b[7:4] != HI_SYSTEM) begin
                        run_stat = b;
                        ph       = PH_DATA1;
                    end else begin
                        run_stat = '0;
                        if (b == STATUS_META) begin
                            ph = PH_MTYPE;
                        end else if (b == STATUS_SYSEX || b == STATUS_ESCAPE) begin
                            len_acc = '0;
                            ph      = PH_LEN;
                        end else begin
                            start_delta();
                            expect_event(EV_STATUS_ERR, '0, '0, '0);
                        end
                    end
                end
            end
            PH_DATA1: first_data_byte(b);
            PH_DATA2: begin
                start_delta();
                if (cur_stat[7:4] == HI_NOTE_OFF || (cur_stat[7:4] == HI_NOTE_ON && b == 0))
                    expect_event(EV_NOTE_OFF, cur_stat[3:0], data1, b);
                else if (cur_stat[7:4] == HI_NOTE_ON)
                    expect_event(EV_NOTE_ON, cur_stat[3:0], data1, b);
            end
            PH_MTYPE: begin
                mtype   = b;
                len_acc = '0;
                ph      = PH_LEN;
            end
            PH_LEN: begin
                len_acc = {len_acc[24:0], b[6:0]};
                if (!b[7]) begin
                    skip_left = len_acc;
                    len_acc   = '0;
                    hdr_cnt   = '0;
                    if (skip_left == 0)
                        payload_consumed();
                    else
                        ph = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (cur_stat == STATUS_META && mtype == META_TEMPO && !tempo_got &&
                    hdr_cnt < TEMPO_BYTES) begin
                    tempo = {tempo[15:0], b};
                    hdr_cnt++;
                end
                skip_left--;
                if (skip_left == 0)
                    payload_consumed();
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_errors++;
        end
    endfunction

    // Result checking and watchdog
    always @(posedge aclk) begin : check_results
        result_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                n_seen++;
                n_kind[m_tuser]++;
                if (pending_events.size() == 0) begin
                    $error("unexpected event: kind %0d, wall_time 0x%0h",
                           m_tuser, m_tdata[51:20]);
                    n_errors++;
                end else begin
                    e = pending_events.pop_front();
                    check_field("event_kind",  32'(e.kind),        32'(m_tuser));
                    check_field("channel",     32'(e.channel),     32'(m_tdata[3:0]));
                    check_field("note",        32'(e.note),        32'(m_tdata[11:4]));
                    check_field("velocity",    32'(e.velocity),    32'(m_tdata[19:12]));
                    check_field("wall_time",   e.wall_time,        m_tdata[51:20]);
                    check_field("divisions",   32'(e.divisions),   32'(m_tdata[67:52]));
                    check_field("track_count", 32'(e.track_count), 32'(m_tdata[83:68]));
                    check_field("tempo_us",    32'(e.tempo_us),    32'(m_tdata[107:84]));
                    check_field("bpm",         32'(e.bpm),         32'(m_tdata[123:108]));
                    check_field("tdata_pad",   '0,                 32'(m_tdata[127:124]));
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Result side back-pressure
    always @(posedge aclk) begin
        if (!sink_idle_on) begin
            m_tready <= 1'b1;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 2) == 0) begin
            m_tready   <= 1'b0;
            ready_hold <= $urandom_range(0, 6);
        end else begin
            m_tready   <= 1'b1;
            ready_hold <= $urandom_range(0, 12);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        parse_byte(b);
        n_bytes++;
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_events.size() != 0)
            @(posedge aclk);
    endtask

    // Variable-length quantity, shortest form
    task automatic send_vlq(input logic [31:0] v);
        logic [6:0] grp [5];
        int         n;
        n = 0;
        do begin
            grp[n] = v[6:0];
            v      = v >> 7;
            n++;
        end while (v != 0);
        for (int i = n - 1; i >= 0; i--)
            send_byte({i != 0, grp[i]});
    endtask

    task automatic send_delta_rand();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            send_vlq($urandom_range(0, 127));
        end else if (sel < 9) begin
            send_vlq($urandom_range(128, (1 << 21) - 1));
        end else begin
            // five groups: the top bits fall off the 32-bit accumulator
            repeat (4) send_byte(8'h80 | 8'($urandom));
            send_byte(8'($urandom_range(0, 127)));
        end
    endtask

    task automatic lead_in();
        if (ph == PH_DELTA)
            send_delta_rand();
    endtask

    function automatic int unsigned rand_len();
        if ($urandom_range(0, 11) == 0)
            return $urandom_range(128, 140);
        return $urandom_range(0, 6);
    endfunction

    task automatic send_payload(input int unsigned len, input logic [23:0] head);
        send_vlq(len);
        for (int i = 0; i < int'(len); i++)
            send_byte(i < 3 ? head[23 - 8 * i -: 8] : 8'($urandom));
    endtask

    task automatic msg_meta(input logic [7:0] kind, input int unsigned len,
                            input logic [23:0] head);
        send_byte(STATUS_META);
        send_byte(kind);
        send_payload(len, head);
    endtask

    task automatic msg_channel(input logic [3:0] hi, input bit running);
        logic [3:0] msg_hi;
        logic [7:0] d1;
        int         r;
        if (running) begin
            msg_hi = run_stat[7:4];
            d1     = 8'($urandom_range(0, 127));
        end else begin
            msg_hi = hi;
            send_byte({hi, 4'($urandom)});
            d1 = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
        end
        send_byte(d1);
        if (msg_hi != HI_PROG_CHANGE && msg_hi != HI_CHAN_PRESS) begin
            r = $urandom_range(0, 7);
            if (r == 0)
                send_byte(8'h00);
            else if (r == 1)
                send_byte(8'($urandom));
            else
                send_byte(8'($urandom_range(1, 127)));
        end
    endtask

    task automatic track_start();
        repeat (8) send_byte(8'($urandom));
    endtask

    task automatic end_track();
        lead_in();
        msg_meta(META_END_TRACK, ($urandom_range(0, 3) == 0) ? 1 : 0, 24'($urandom));
    endtask

    task automatic random_event();
        int         sel;
        logic [3:0] hi;
        logic [7:0] b;
        lead_in();
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
            if (run_stat[7] && $urandom_range(0, 2) == 0) begin
                msg_channel(HI_NOTE_ON, 1'b1);
            end else if (sel < 28) begin
                msg_channel(HI_NOTE_ON, 1'b0);
            end else if (sel < 42) begin
                msg_channel(HI_NOTE_OFF, 1'b0);
            end else begin
                case ($urandom_range(0, 4))
                    0:       hi = HI_POLY_PRESS;
                    1:       hi = HI_CONTROL;
                    2:       hi = HI_PROG_CHANGE;
                    3:       hi = HI_CHAN_PRESS;
                    default: hi = HI_PITCH_BEND;
                endcase
                msg_channel(hi, 1'b0);
            end
        end else if (sel < 62) begin
            do
                b = 8'($urandom);
            while (b == META_END_TRACK || b == META_TEMPO);
            msg_meta(b, rand_len(), 24'($urandom));
        end else if (sel < 70) begin
            msg_meta(META_TEMPO, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 3,
                     24'($urandom));
        end else if (sel < 80) begin
            send_byte($urandom_range(0, 1) ? STATUS_SYSEX : STATUS_ESCAPE);
            send_payload(rand_len(), 24'($urandom));
        end else if (sel < 90) begin
            do
                b = 8'($urandom_range(8'hF1, 8'hFE));
            while (b == STATUS_ESCAPE);
            send_byte(b);
        end else if (!run_stat[7]) begin
            // stray data byte, parser stays waiting for a status
            send_byte(8'($urandom_range(0, 127)));
        end else begin
            msg_channel(HI_NOTE_ON, 1'b0);
        end
    endtask

    // Header chunk with three surplus bytes after the standard six
    task automatic test_header();
        file_tracks = 16'($urandom_range(8, 11));
        file_div    = 16'($urandom);
        repeat (4) send_byte(8'($urandom));
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h09);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(file_tracks[15:8]);
        send_byte(file_tracks[7:0]);
        send_byte(file_div[15:8]);
        send_byte(file_div[7:0]);
        repeat (3) send_byte(8'($urandom));
    endtask

    task automatic test_note_events();
        track_start();
        send_vlq(0);
        send_byte({HI_NOTE_ON, 4'h0});
        send_byte(8'h00);
        send_byte(8'h7F);
        // running status, velocity zero reads as note off
        send_vlq(1);
        send_byte(8'h3C);
        send_byte(8'h00);
        send_vlq(32'h0FFF_FFFF);
        send_byte({HI_NOTE_OFF, 4'hF});
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_vlq(0);
        send_byte({HI_PROG_CHANGE, 4'h5});
        send_byte(8'h12);
        send_vlq(2);
        send_byte(8'h13);
        send_vlq(0);
        send_byte({HI_CHAN_PRESS, 4'h3});
        send_byte(8'h40);
        send_vlq(3);
        send_byte({HI_PITCH_BEND, 4'h7});
        send_byte(8'h00);
        send_byte(8'h40);
        send_vlq(0);
        send_byte({HI_CONTROL, 4'h1});
        send_byte(8'h07);
        send_byte(8'h64);
        // all-ones delta wraps the track time
        repeat (4) send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte({HI_NOTE_ON, 4'hA});
        send_byte(8'h80);
        send_byte(8'h01);
    endtask

    task automatic test_status_errors();
        send_vlq(0);
        send_byte(STATUS_SYSEX);
        send_payload(2, 24'h0A0B0C);
        send_vlq(4);
        send_byte(8'h05);
        send_byte(8'h7F);
        send_byte(8'hF4);
        send_vlq(0);
        send_byte(STATUS_ESCAPE);
        send_payload(0, 24'h0);
        send_vlq(0);
        send_byte(8'hFE);
    endtask

    task automatic test_meta_events();
        logic [23:0] first_tempo;
        case ($urandom_range(0, 2))
            0:       first_tempo = 24'($urandom_range(1, 900));
            1:       first_tempo = 24'd500000;
            default: first_tempo = 24'hFF_FFFF;
        endcase
        send_vlq(0);
        msg_meta(META_TEMPO, 4, first_tempo);
        send_vlq(5);
        msg_meta(META_TEMPO, 3, 24'($urandom));
        send_vlq(0);
        msg_meta(META_TRACK_NAME, 2, 24'($urandom));
        end_track();
    endtask

    task automatic test_random_tracks();
        int budget;
        int start;
        budget = RANDOM_BYTES / (int'(file_tracks) - 2);
        for (int t = 2; t < int'(file_tracks); t++) begin
            src_idle_on  = $urandom_range(0, 3) != 0;
            sink_idle_on = $urandom_range(0, 3) != 0;
            if (t == int'(file_tracks) / 2 + 1)
                wait_results_drained();
            track_start();
            start = n_bytes;
            while (n_bytes - start < budget)
                random_event();
            end_track();
        end
    endtask

    // Last track runs at full rate; its end is the end of the file
    task automatic test_last_track();
        wait_results_drained();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        track_start();
        repeat (12) random_event();
        end_track();
        repeat (5) send_byte(8'($urandom));
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_header();
        test_note_events();
        test_status_errors();
        test_meta_events();
        test_random_tracks();
        test_last_track();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_events.size() != 0) begin
            $error("%0d expected events never arrived", pending_events.size());
            n_errors++;
        end
        $display("tb: %0d file bytes over %0d tracks, %0d events checked",
                 n_bytes, file_tracks, n_seen);
        $display("tb: notes %0d, tempo %0d, track ends %0d, status errors %0d",
                 n_kind[EV_NOTE_ON] + n_kind[EV_NOTE_OFF], n_kind[EV_TEMPO],
                 n_kind[EV_END_TRACK] + n_kind[EV_END_FILE], n_kind[EV_STATUS_ERR]);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
